>>> sv/sius_pkg.sv
// Shared types, constants and helper functions for the staged image update sequencer.
`timescale 1ns / 1ps
package sius_pkg;

  // Sizing
  localparam int unsigned CHUNK_LIMIT  = 4096;
  localparam int unsigned SECTOR_BYTES = 4096;
  localparam int unsigned SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int unsigned SLOT_COUNT   = 5;
  localparam int unsigned OFFSET_COUNT = 5;
  localparam int unsigned SLOT_W       = 3;

  localparam logic [7:0]  START_MIN_LEN = 8'd38;
  localparam logic [7:0]  CHUNK_MIN_LEN = 8'd5;
  localparam logic [15:0] ACK_START     = 16'hFFFF;
  localparam logic [12:0] SECTOR_SAT    = 13'd8191;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGING_BASE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RUNNING_BASE = 3'd6;

  localparam logic [SLOT_COUNT-1:0][23:0] LIMIT_RESET = {
    24'd65536, 24'd81920, 24'd65536, 24'd65536, 24'd51200
  };

  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_CHUNK  = 3'd1,
    MODE_COMMIT = 3'd2,
    MODE_ABORT  = 3'd3
  } mode_e;

  typedef enum logic [1:0] {
    REPLY_NONE     = 2'd0,
    REPLY_ACK      = 2'd1,
    REPLY_ERROR    = 2'd2,
    REPLY_COMPLETE = 2'd3
  } reply_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_TOO_LARGE = 3'd1,
    ERR_ERASE     = 3'd2,
    ERR_WRITE     = 3'd3,
    ERR_DIGEST    = 3'd4,
    ERR_SEQUENCE  = 3'd5,
    ERR_INVALID   = 3'd6
  } err_e;

  typedef enum logic [1:0] {
    FAULT_OK    = 2'd0,
    FAULT_ERASE = 2'd1,
    FAULT_WRITE = 2'd2
  } fault_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  cmd_length;
    logic [7:0]  model_number;
    logic [31:0] image_size;
    logic [15:0] chunk_number;
    logic [15:0] chunk_bytes;
    logic [1:0]  flash_fault;
    logic        digest_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [15:0] ack_value;
    logic [2:0]  err_code;
    logic [7:0]  done_model;
    logic [31:0] staging_addr;
    logic [31:0] promote_addr;
    logic [12:0] sector_count;
    logic [23:0] byte_count;
    logic        session_open;
  } out_item_t;

  typedef struct packed {
    logic              active;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        model;
    logic [23:0]       total;
    logic [15:0]       expected;
    logic [23:0]       written;
  } session_t;

  typedef struct packed {
    logic [SLOT_COUNT-1:0][23:0] limit;
    logic [31:0]                 staging_base;
    logic [31:0]                 running_base;
  } cfg_t;

  // Bank offset of each model slot.
  function automatic logic [31:0] slot_offset(input logic [SLOT_W-1:0] slot);
    logic [31:0] off;
    case (slot)
      3'd0:    off = 32'h0000_0000;
      3'd1:    off = 32'h0000_C800;
      3'd2:    off = 32'h0001_C800;
      3'd3:    off = 32'h0002_C800;
      3'd4:    off = 32'h0004_0800;
      default: off = 32'h0000_0000;
    endcase
    return off;
  endfunction

  // Ceiling of bytes over the sector size, saturated.
  function automatic logic [12:0] sectors_for(input logic [23:0] bytes);
    logic [24:0] sum;
    logic [24:0] n;
    sum = {1'b0, bytes} + 25'(SECTOR_BYTES - 1);
    n   = sum >> SECTOR_SHIFT;
    return (n > 25'(SECTOR_SAT)) ? SECTOR_SAT : n[12:0];
  endfunction

endpackage

>>> sv/sius_cfg.sv
// Configuration registers: per-slot size limits and the two bank base addresses.
`timescale 1ns / 1ps
module sius_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sius_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sius_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output sius_pkg::cfg_t                  cfg_o
);

  sius_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit        <= sius_pkg::LIMIT_RESET;
      cfg_q.staging_base <= '0;
      cfg_q.running_base <= '0;
    end else if (cfg_we_i) begin
      for (int i = 0; i < sius_pkg::SLOT_COUNT; i++) begin
        if (cfg_idx_i == sius_pkg::CFG_IDX_W'(i)) begin
          cfg_q.limit[i] <= cfg_wdata_i[23:0];
        end
      end
      if (cfg_idx_i == sius_pkg::CFG_STAGING_BASE) begin
        cfg_q.staging_base <= cfg_wdata_i;
      end
      if (cfg_idx_i == sius_pkg::CFG_RUNNING_BASE) begin
        cfg_q.running_base <= cfg_wdata_i;
      end
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/sius_sess.sv
// Session state registers, loaded with the next state when an item is processed.
`timescale 1ns / 1ps
module sius_sess (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  sius_pkg::session_t sess_d_i,
  output sius_pkg::session_t sess_o
);

  sius_pkg::session_t sess_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sess_q <= '0;
    end else if (load_i) begin
      sess_q <= sess_d_i;
    end
  end

  assign sess_o = sess_q;

endmodule

>>> sv/sius_step.sv
// Command decode, checks and address arithmetic for one item.
`timescale 1ns / 1ps
module sius_step (
  input  sius_pkg::in_item_t  item_i,
  input  sius_pkg::session_t  sess_i,
  input  sius_pkg::cfg_t      cfg_i,
  output logic                emit_o,
  output sius_pkg::out_item_t res_o,
  output sius_pkg::session_t  sess_d_o
);

  logic [sius_pkg::SLOT_W-1:0] new_slot;
  logic                        model_known;
  logic [23:0]                 slot_limit;
  logic [12:0]                 start_secs;
  logic [31:0]                 start_saddr;
  logic [sius_pkg::SLOT_W-1:0] cur_slot;
  logic [31:0]                 cur_saddr;
  logic [31:0]                 cur_paddr;
  logic [31:0]                 chunk_saddr;
  logic [24:0]                 chunk_sum;
  logic [12:0]                 commit_secs;

  assign new_slot    = sius_pkg::SLOT_W'(item_i.model_number - 8'd1);
  assign model_known = (item_i.model_number != 8'd0) &&
                       (item_i.model_number <= 8'(sius_pkg::SLOT_COUNT)) &&
                       (item_i.model_number <= 8'(sius_pkg::OFFSET_COUNT));
  assign slot_limit  = model_known ? cfg_i.limit[new_slot] : '0;
  assign start_secs  = sius_pkg::sectors_for(item_i.image_size[23:0]);
  assign start_saddr = cfg_i.staging_base + sius_pkg::slot_offset(new_slot);

  // Guard against a slot that has no bank offset.
  assign cur_slot    = (sess_i.slot < sius_pkg::SLOT_W'(sius_pkg::OFFSET_COUNT)) ?
                       sess_i.slot : '0;
  assign cur_saddr   = cfg_i.staging_base + sius_pkg::slot_offset(cur_slot);
  assign cur_paddr   = cfg_i.running_base + sius_pkg::slot_offset(cur_slot);
  assign chunk_saddr = cur_saddr + {8'd0, sess_i.written};
  assign chunk_sum   = {1'b0, sess_i.written} + {9'd0, item_i.chunk_bytes};
  assign commit_secs = sius_pkg::sectors_for(sess_i.written);

  always_comb begin
    emit_o   = 1'b0;
    res_o    = '0;
    sess_d_o = sess_i;
    if (item_i.cmd_length != 8'd0) begin
      case (item_i.mode)
        sius_pkg::MODE_START: begin
          emit_o = 1'b1;
          res_o.reply_kind = sius_pkg::REPLY_ERROR;
          if (item_i.cmd_length < sius_pkg::START_MIN_LEN || !model_known) begin
            res_o.err_code = sius_pkg::ERR_INVALID;
          end else if (item_i.image_size > {8'd0, slot_limit}) begin
            res_o.err_code = sius_pkg::ERR_TOO_LARGE;
          end else if (item_i.flash_fault == sius_pkg::FAULT_ERASE &&
                       start_secs != 13'd0) begin
            res_o.err_code     = sius_pkg::ERR_ERASE;
            res_o.staging_addr = start_saddr;
            res_o.sector_count = start_secs;
          end else begin
            res_o.reply_kind   = sius_pkg::REPLY_ACK;
            res_o.ack_value    = sius_pkg::ACK_START;
            res_o.staging_addr = start_saddr;
            res_o.sector_count = start_secs;
            sess_d_o.active    = 1'b1;
            sess_d_o.slot      = new_slot;
            sess_d_o.model     = item_i.model_number;
            sess_d_o.total     = item_i.image_size[23:0];
            sess_d_o.expected  = '0;
            sess_d_o.written   = '0;
          end
        end
        sius_pkg::MODE_CHUNK: begin
          emit_o = 1'b1;
          res_o.reply_kind = sius_pkg::REPLY_ERROR;
          if (!sess_i.active || item_i.cmd_length < sius_pkg::CHUNK_MIN_LEN) begin
            res_o.err_code = sius_pkg::ERR_INVALID;
          end else if (item_i.chunk_number != sess_i.expected) begin
            res_o.err_code = sius_pkg::ERR_SEQUENCE;
          end else if (item_i.chunk_bytes > 16'(sius_pkg::CHUNK_LIMIT)) begin
            res_o.err_code = sius_pkg::ERR_INVALID;
          end else if (chunk_sum > {1'b0, sess_i.total}) begin
            res_o.err_code = sius_pkg::ERR_TOO_LARGE;
          end else if (item_i.flash_fault == sius_pkg::FAULT_WRITE) begin
            res_o.err_code     = sius_pkg::ERR_WRITE;
            res_o.staging_addr = chunk_saddr;
            res_o.byte_count   = {8'd0, item_i.chunk_bytes};
          end else begin
            res_o.reply_kind   = sius_pkg::REPLY_ACK;
            res_o.ack_value    = item_i.chunk_number;
            res_o.staging_addr = chunk_saddr;
            res_o.byte_count   = {8'd0, item_i.chunk_bytes};
            sess_d_o.written   = chunk_sum[23:0];
            sess_d_o.expected  = sess_i.expected + 16'd1;
          end
        end
        sius_pkg::MODE_COMMIT: begin
          emit_o = 1'b1;
          res_o.reply_kind = sius_pkg::REPLY_ERROR;
          if (!sess_i.active) begin
            res_o.err_code = sius_pkg::ERR_INVALID;
          end else if (!item_i.digest_ok) begin
            res_o.err_code     = sius_pkg::ERR_DIGEST;
            res_o.staging_addr = cur_saddr;
            res_o.byte_count   = sess_i.written;
          end else begin
            res_o.staging_addr = cur_saddr;
            res_o.promote_addr = cur_paddr;
            res_o.sector_count = commit_secs;
            res_o.byte_count   = sess_i.written;
            if (item_i.flash_fault == sius_pkg::FAULT_ERASE && commit_secs != 13'd0) begin
              res_o.err_code = sius_pkg::ERR_ERASE;
            end else if (item_i.flash_fault == sius_pkg::FAULT_WRITE &&
                         commit_secs != 13'd0) begin
              res_o.err_code = sius_pkg::ERR_WRITE;
            end else begin
              res_o.reply_kind = sius_pkg::REPLY_COMPLETE;
              res_o.done_model = sess_i.model;
              sess_d_o         = '0;
            end
          end
        end
        sius_pkg::MODE_ABORT: begin
          sess_d_o.active = 1'b0;
        end
        default: begin
          emit_o           = 1'b1;
          res_o.reply_kind = sius_pkg::REPLY_ERROR;
          res_o.err_code   = sius_pkg::ERR_INVALID;
        end
      endcase
    end
    // Any error closes the session.
    if (emit_o && res_o.reply_kind == sius_pkg::REPLY_ERROR) begin
      sess_d_o.active = 1'b0;
    end
    res_o.session_open = sess_d_o.active;
  end

endmodule

>>> sv/staged_image_update_sequencer.sv
// Top level: input register, command step logic, session state and result register.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+-------------------------------
//  command  | in_valid_i  / in_stall_o      | in_item_i  (sius_pkg::in_item_t)
//  reply    | out_valid_o / out_stall_i     | out_item_o (sius_pkg::out_item_t)
//  config   | cfg_we_i                      | cfg_idx_i, cfg_wdata_i
//
// Each item passes the input register, then the result register; one item enters per cycle unless the reply stalls.
// The session state and the reply are loaded at the same edge, so the next item sees it.
// Zero-length and abort items pass through without producing a reply.
// A stalled reply holds the result register and, behind it, the input register.
// Reset clears the session and loads the default size limits; bases reset to zero.
`timescale 1ns / 1ps
module staged_image_update_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sius_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sius_pkg::out_item_t             out_item_o,
  input  logic                            cfg_we_i,
  input  logic [sius_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sius_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  logic                in_valid_q;
  sius_pkg::in_item_t  in_item_q;
  logic                out_valid_q;
  sius_pkg::out_item_t out_item_q;
  logic                advance;
  logic                fire;
  logic                in_accept;
  logic                emit;
  sius_pkg::out_item_t res;
  sius_pkg::session_t  sess;
  sius_pkg::session_t  sess_d;
  sius_pkg::cfg_t      cfg;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_item_q <= res;
    end
  end

  sius_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sius_step u_step (
    .item_i   (in_item_q),
    .sess_i   (sess),
    .cfg_i    (cfg),
    .emit_o   (emit),
    .res_o    (res),
    .sess_d_o (sess_d)
  );

  sius_sess u_sess (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire),
    .sess_d_i (sess_d),
    .sess_o   (sess)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef ASSERT_OFF
  // A reply always carries a kind.
  a_reply_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_item_q.reply_kind != sius_pkg::REPLY_NONE)
    else $error("reply without kind");

  // An error reply reports the session closed.
  a_error_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.reply_kind == sius_pkg::REPLY_ERROR
      |-> !out_item_q.session_open)
    else $error("error reply with session open");

  // A completion leaves the session state fully cleared.
  a_complete_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && emit && res.reply_kind == sius_pkg::REPLY_COMPLETE |=> sess == '0)
    else $error("session not cleared after completion");

  // The reported session flag matches the state that was loaded.
  a_open_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && emit |=> out_item_q.session_open == sess.active)
    else $error("session_open disagrees with session state");

  // A held item in the input register stalls the command side.
  a_hold_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && out_stall_i |-> in_stall_o && !fire)
    else $error("input advanced under a stalled reply");
`endif

endmodule

>>> bench/staged_image_update_sequencer_tb.sv
// Self-checking bench for the staged image update sequencer: directed, random and burst tests.
`timescale 1ns / 1ps
module staged_image_update_sequencer_tb;
  import sius_pkg::*;

  localparam int NUM_SLOTS = 5;
  localparam logic [7:0] START_LEN_MIN = 8'd38;
  localparam logic [7:0] CHUNK_LEN_MIN = 8'd5;
  localparam logic [15:0] CHUNK_MAX = 16'd4096;
  localparam logic [15:0] START_ACK = 16'hFFFF;
  localparam logic [2:0] MODE_UNKNOWN = 3'd7;
  localparam logic [1:0] FAULT_NONE_APPLIES = 2'd3;
  localparam logic [2:0] CFG_LIMIT_FIRST = 3'd0;
  localparam logic [NUM_SLOTS-1:0][31:0] BANK_OFFSET = {
    32'h0004_0800, 32'h0002_C800, 32'h0001_C800, 32'h0000_C800, 32'h0000_0000
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  staged_image_update_sequencer uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i(in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o(out_item_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // Predictor copy of configuration and session
  logic [23:0] size_cap [NUM_SLOTS] = '{24'd51200, 24'd65536, 24'd65536, 24'd81920, 24'd65536};
  logic [31:0] stage_base = '0;
  logic [31:0] run_base = '0;
  bit          sess_active = 1'b0;
  logic [2:0]  sess_slot = '0;
  logic [7:0]  sess_model = '0;
  logic [23:0] sess_total = '0;
  logic [15:0] sess_next_index = '0;
  logic [23:0] sess_written = '0;

  out_item_t expected_replies [$];
  int mismatches = 0;
  int commands_counted = 0;
  bit idling_on = 1'b1;
  int reply_hold = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 50) $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  function automatic logic [12:0] sectors_needed(input logic [31:0] nbytes);
    logic [32:0] whole;
    whole = ({1'b0, nbytes} + 33'd4095) >> 12;
    return (whole > 33'd8191) ? 13'd8191 : whole[12:0];
  endfunction

  // Apply one command to the predicted session; return 1 if it yields a reply.
  function automatic bit predict_reply(input in_item_t c, output out_item_t r);
    logic [2:0] slot;
    logic [12:0] secs;
    r = '0;
    if (c.cmd_length == 8'd0) return 1'b0;
    r.reply_kind = REPLY_ERROR;
    r.err_code = ERR_INVALID;
    slot = sess_slot;
    case (c.mode)
      MODE_START: begin
        if (c.cmd_length >= START_LEN_MIN && c.model_number >= 8'd1 &&
            c.model_number <= 8'(NUM_SLOTS)) begin
          slot = 3'(c.model_number - 8'd1);
          if (c.image_size > {8'd0, size_cap[slot]}) begin
            r.err_code = ERR_TOO_LARGE;
          end else begin
            secs = sectors_needed(c.image_size);
            r.staging_addr = stage_base + BANK_OFFSET[slot];
            r.sector_count = secs;
            if (c.flash_fault == FAULT_ERASE && secs != 0) begin
              r.err_code = ERR_ERASE;
            end else begin
              sess_active = 1'b1;
              sess_slot = slot;
              sess_model = c.model_number;
              sess_total = c.image_size[23:0];
              sess_next_index = '0;
              sess_written = '0;
              r.reply_kind = REPLY_ACK;
              r.err_code = ERR_NONE;
              r.ack_value = START_ACK;
            end
          end
        end
      end
      MODE_CHUNK: begin
        if (!sess_active || c.cmd_length < CHUNK_LEN_MIN) begin
          r.err_code = ERR_INVALID;
        end else if (c.chunk_number != sess_next_index) begin
          r.err_code = ERR_SEQUENCE;
        end else if (c.chunk_bytes > CHUNK_MAX) begin
          r.err_code = ERR_INVALID;
        end else if ({1'b0, sess_written} + 25'(c.chunk_bytes) > {1'b0, sess_total}) begin
          r.err_code = ERR_TOO_LARGE;
        end else begin
          r.staging_addr = stage_base + BANK_OFFSET[slot] + {8'd0, sess_written};
          r.byte_count = 24'(c.chunk_bytes);
          if (c.flash_fault == FAULT_WRITE) begin
            r.err_code = ERR_WRITE;
          end else begin
            sess_written = sess_written + 24'(c.chunk_bytes);
            sess_next_index = sess_next_index + 16'd1;
            r.reply_kind = REPLY_ACK;
            r.err_code = ERR_NONE;
            r.ack_value = c.chunk_number;
          end
        end
      end
      MODE_COMMIT: begin
        if (sess_active) begin
          r.staging_addr = stage_base + BANK_OFFSET[slot];
          r.byte_count = sess_written;
          if (!c.digest_ok) begin
            r.err_code = ERR_DIGEST;
          end else begin
            secs = sectors_needed({8'd0, sess_written});
            r.promote_addr = run_base + BANK_OFFSET[slot];
            r.sector_count = secs;
            if (c.flash_fault == FAULT_ERASE && secs != 0) begin
              r.err_code = ERR_ERASE;
            end else if (c.flash_fault == FAULT_WRITE && secs != 0) begin
              r.err_code = ERR_WRITE;
            end else begin
              r.reply_kind = REPLY_COMPLETE;
              r.err_code = ERR_NONE;
              r.done_model = sess_model;
              sess_active = 1'b0;
              sess_slot = '0;
              sess_model = '0;
              sess_total = '0;
              sess_next_index = '0;
              sess_written = '0;
            end
          end
        end
      end
      MODE_ABORT: begin
        sess_active = 1'b0;
        return 1'b0;
      end
      default: r.err_code = ERR_INVALID;
    endcase
    if (r.reply_kind == REPLY_ERROR) sess_active = 1'b0;
    r.session_open = sess_active;
    return 1'b1;
  endfunction

  function automatic int idle_span();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 2);
    if (pick < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic in_item_t random_command();
    in_item_t c;
    c.mode = 3'($urandom_range(0, 7));
    c.cmd_length = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
    c.model_number = 8'($urandom);
    c.image_size = $urandom;
    c.chunk_number = 16'($urandom);
    c.chunk_bytes = 16'($urandom);
    c.flash_fault = 2'($urandom);
    c.digest_ok = 1'($urandom);
    return c;
  endfunction

  task automatic send_command(input in_item_t c);
    out_item_t r;
    int gap;
    gap = (idling_on && $urandom_range(0, 2) == 0) ? idle_span() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      in_item_i = random_command();
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_item_i = c;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (c.cmd_length != 8'd0) commands_counted++;
    if (predict_reply(c, r)) expected_replies.push_back(r);
  endtask

  task automatic issue_command(input logic [2:0] mode, input logic [7:0] len,
                               input logic [7:0] model, input logic [31:0] size,
                               input logic [15:0] index, input logic [15:0] nbytes,
                               input logic [1:0] fault, input logic digest);
    in_item_t c;
    c.mode = mode;
    c.cmd_length = len;
    c.model_number = model;
    c.image_size = size;
    c.chunk_number = index;
    c.chunk_bytes = nbytes;
    c.flash_fault = fault;
    c.digest_ok = digest;
    send_command(c);
  endtask

  // Drop valid and let every reply and any reply-less item drain.
  task automatic drain_commands();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_STAGING_BASE) stage_base = data;
    else if (idx == CFG_RUNNING_BASE) run_base = data;
    else if (idx < CFG_LIMIT_FIRST + 3'(NUM_SLOTS)) size_cap[idx - CFG_LIMIT_FIRST] = data[23:0];
  endtask

  task automatic write_limits(input logic [31:0] value, input bit scatter);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (scatter) begin
        value = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 90000);
      end
      write_register(CFG_LIMIT_FIRST + 3'(i), value);
    end
  endtask

  // One update session: start, a few chunks, commit, with occasional faults and breaks.
  task automatic one_session();
    in_item_t c;
    int n_chunks;
    int room;
    int hi;
    int pick;
    logic [2:0] slot;
    c = random_command();
    c.mode = MODE_START;
    if ($urandom_range(0, 9) != 0) c.model_number = 8'($urandom_range(1, NUM_SLOTS));
    if ($urandom_range(0, 9) != 0) c.cmd_length = 8'($urandom_range(38, 255));
    if ($urandom_range(0, 4) != 0) c.flash_fault = FAULT_OK;
    if (c.model_number >= 8'd1 && c.model_number <= 8'(NUM_SLOTS)) begin
      slot = 3'(c.model_number - 8'd1);
      pick = $urandom_range(0, 19);
      if (pick == 0) c.image_size = {8'd0, size_cap[slot]} + 32'd1;
      else if (pick == 1) c.image_size = {8'd0, size_cap[slot]};
      else if (pick == 3) c.image_size = $urandom_range(0, size_cap[slot]);
      else if (pick != 2) begin
        c.image_size = $urandom_range(0, (size_cap[slot] > 24000) ? 24000 : size_cap[slot]);
      end
    end
    send_command(c);
    n_chunks = $urandom_range(0, 6);
    for (int i = 0; i < n_chunks; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        c = random_command();
        c.mode = MODE_ABORT;
        send_command(c);
      end
      c = random_command();
      c.mode = MODE_CHUNK;
      if ($urandom_range(0, 19) != 0) c.cmd_length = 8'($urandom_range(5, 255));
      if ($urandom_range(0, 19) != 0) c.chunk_number = sess_next_index;
      room = sess_active ? int'(sess_total) - int'(sess_written) : 0;
      hi = (room > 4032) ? 4096 : room + 64;
      if ($urandom_range(0, 19) != 0) c.chunk_bytes = 16'($urandom_range(0, hi));
      if ($urandom_range(0, 9) != 0) c.flash_fault = FAULT_OK;
      send_command(c);
    end
    c = random_command();
    c.mode = MODE_COMMIT;
    if ($urandom_range(0, 19) != 0) c.cmd_length = 8'($urandom_range(1, 255));
    if ($urandom_range(0, 9) != 0) c.digest_ok = 1'b1;
    if ($urandom_range(0, 4) != 0) c.flash_fault = FAULT_OK;
    send_command(c);
  endtask

  task automatic run_update_sessions(input int count);
    int stop_at;
    stop_at = commands_counted + count;
    while (commands_counted < stop_at) begin
      idling_on = ($urandom_range(0, 7) != 0);
      if ($urandom_range(0, 99) < 15) send_command(random_command());
      else one_session();
    end
    idling_on = 1'b1;
  endtask

  task automatic test_directed_commands();
    issue_command(MODE_START, 8'd0, 8'd1, 32'd100, 16'd0, 16'd0, FAULT_OK, 1'b1);
    issue_command(MODE_UNKNOWN, 8'd255, 8'd1, 32'd0, 16'd0, 16'd0, FAULT_OK, 1'b1);
    issue_command(MODE_START, 8'd37, 8'd1, 32'd100, 16'd0, 16'd0, FAULT_OK, 1'b1);
    issue_command(MODE_START, 8'd38, 8'd0, 32'd100, 16'd0, 16'd0, FAULT_OK, 1'b1);
    issue_command(MODE_START, 8'd255, 8'd6, 32'd100, 16'd0, 16'd0, FAULT_OK, 1'b1);
    issue_command(MODE_START, 8'd38, 8'd1, 32'd51201, 16'd0, 16'd0, FAULT_OK, 1'b1);
    issue_command(MODE_COMMIT, 8'd1, 8'd0, 32'd0, 16'd0, 16'd0, FAULT_OK, 1'b1);
    issue_command(MODE_CHUNK, 8'd5, 8'd0, 32'd0, 16'd0, 16'd0, FAULT_OK, 1'b1);
    issue_command(MODE_START, 8'd38, 8'd2, 32'd65536, 16'd0, 16'd0, FAULT_ERASE, 1'b1);
    // empty image: an erase fault does not apply, nor a write fault at commit
    issue_command(MODE_START, 8'd38, 8'd3, 32'd0, 16'd0, 16'd0, FAULT_ERASE, 1'b1);
    issue_command(MODE_COMMIT, 8'd1, 8'd0, 32'd0, 16'd0, 16'd0, FAULT_WRITE, 1'b1);
    issue_command(MODE_START, 8'd200, 8'd4, 32'd81920, 16'd0, 16'd0, FAULT_NONE_APPLIES, 1'b0);
    issue_command(MODE_CHUNK, 8'd4, 8'd0, 32'd0, 16'd0, 16'd0, FAULT_OK, 1'b1);
    // index is checked before length, length before total
    issue_command(MODE_START, 8'd38, 8'd5, 32'd100, 16'd0, 16'd0, FAULT_OK, 1'b1);
    issue_command(MODE_CHUNK, 8'd5, 8'd0, 32'd0, 16'd1, 16'd4097, FAULT_OK, 1'b1);
    issue_command(MODE_START, 8'd38, 8'd5, 32'd100, 16'd0, 16'd0, FAULT_OK, 1'b1);
    issue_command(MODE_CHUNK, 8'd5, 8'd0, 32'd0, 16'd0, 16'd4097, FAULT_OK, 1'b1);
    issue_command(MODE_START, 8'd38, 8'd1, 32'd51200, 16'd0, 16'd0, FAULT_OK, 1'b1);
    issue_command(MODE_CHUNK, 8'd5, 8'd0, 32'd0, 16'd0, 16'd4096, FAULT_ERASE, 1'b1);
    issue_command(MODE_CHUNK, 8'd5, 8'd0, 32'd0, 16'd1, 16'd4096, FAULT_WRITE, 1'b1);
    issue_command(MODE_START, 8'd38, 8'd2, 32'd8192, 16'd0, 16'd0, FAULT_OK, 1'b1);
    issue_command(MODE_CHUNK, 8'd5, 8'd0, 32'd0, 16'd0, 16'd4096, FAULT_OK, 1'b1);
    issue_command(MODE_COMMIT, 8'd1, 8'd0, 32'd0, 16'd0, 16'd0, FAULT_OK, 1'b0);
    issue_command(MODE_START, 8'd38, 8'd3, 32'd8192, 16'd0, 16'd0, FAULT_OK, 1'b1);
    issue_command(MODE_CHUNK, 8'd5, 8'd0, 32'd0, 16'd0, 16'd4096, FAULT_OK, 1'b1);
    issue_command(MODE_COMMIT, 8'd1, 8'd0, 32'd0, 16'd0, 16'd0, FAULT_ERASE, 1'b1);
    issue_command(MODE_START, 8'd38, 8'd4, 32'd8192, 16'd0, 16'd0, FAULT_OK, 1'b1);
    issue_command(MODE_CHUNK, 8'd5, 8'd0, 32'd0, 16'd0, 16'd1, FAULT_OK, 1'b1);
    issue_command(MODE_COMMIT, 8'd1, 8'd0, 32'd0, 16'd0, 16'd0, FAULT_WRITE, 1'b1);
    issue_command(MODE_START, 8'd38, 8'd5, 32'd4096, 16'd0, 16'd0, FAULT_OK, 1'b1);
    issue_command(MODE_ABORT, 8'd1, 8'd0, 32'd0, 16'd0, 16'd0, FAULT_OK, 1'b1);
    issue_command(MODE_COMMIT, 8'd1, 8'd0, 32'd0, 16'd0, 16'd0, FAULT_OK, 1'b1);
    issue_command(MODE_START, 8'd38, 8'd1, 32'd5000, 16'd0, 16'd0, FAULT_OK, 1'b1);
    issue_command(MODE_CHUNK, 8'd5, 8'd0, 32'd0, 16'd0, 16'd4096, FAULT_OK, 1'b1);
    issue_command(MODE_CHUNK, 8'd5, 8'd0, 32'd0, 16'd1, 16'd904, FAULT_NONE_APPLIES, 1'b1);
    issue_command(MODE_COMMIT, 8'd255, 8'd0, 32'd0, 16'd0, 16'd0, FAULT_OK, 1'b1);
  endtask

  task automatic test_limit_extremes();
    drain_commands();
    write_limits(32'hFFFF_FFFF, 1'b0);
    write_register(CFG_STAGING_BASE, 32'hFFFF_FFFF);
    write_register(CFG_RUNNING_BASE, 32'hFFFF_F000);
    run_update_sessions(350);
  endtask

  task automatic test_zero_limits();
    drain_commands();
    write_limits(32'd0, 1'b0);
    write_register(CFG_STAGING_BASE, 32'd0);
    write_register(CFG_RUNNING_BASE, 32'h8000_0000);
    run_update_sessions(150);
  endtask

  task automatic test_random_limits();
    for (int round = 0; round < 3; round++) begin
      drain_commands();
      write_limits(32'd0, 1'b1);
      write_register(CFG_STAGING_BASE, $urandom);
      write_register(CFG_RUNNING_BASE, $urandom);
      run_update_sessions(230);
    end
  endtask

  // Stream full chunks back to back up to the slot limit, then complete the session.
  task automatic test_back_to_back_chunks();
    drain_commands();
    write_register(CFG_LIMIT_FIRST, 32'd65536);
    idling_on = 1'b0;
    issue_command(MODE_START, 8'd38, 8'd1, 32'd65536, 16'd0, 16'd0, FAULT_OK, 1'b1);
    for (int i = 0; i < 16; i++) begin
      issue_command(MODE_CHUNK, 8'd5, 8'd0, 32'd0, sess_next_index,
                    CHUNK_MAX, FAULT_OK, 1'b1);
    end
    issue_command(MODE_COMMIT, 8'd1, 8'd0, 32'd0, 16'd0, 16'd0, FAULT_OK, 1'b1);
    idling_on = 1'b1;
  endtask

  // Reply-side stall: random bursts, no new burst starting while idling is off.
  always @(negedge clk_i) begin
    if (reply_hold > 0) begin
      reply_hold--;
    end else if (!idling_on || out_stall_i) begin
      out_stall_i = 1'b0;
      reply_hold = $urandom_range(0, 12);
    end else begin
      out_stall_i = 1'b1;
      reply_hold = idle_span() - 1;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("reply with none pending", 32'(out_item_o.reply_kind), 32'd0);
      end else begin
        want = expected_replies.pop_front();
        if (out_item_o.reply_kind !== want.reply_kind)
          report_mismatch("reply_kind", 32'(out_item_o.reply_kind), 32'(want.reply_kind));
        if (out_item_o.ack_value !== want.ack_value)
          report_mismatch("ack_value", 32'(out_item_o.ack_value), 32'(want.ack_value));
        if (out_item_o.err_code !== want.err_code)
          report_mismatch("err_code", 32'(out_item_o.err_code), 32'(want.err_code));
        if (out_item_o.done_model !== want.done_model)
          report_mismatch("done_model", 32'(out_item_o.done_model), 32'(want.done_model));
        if (out_item_o.staging_addr !== want.staging_addr)
          report_mismatch("staging_addr", out_item_o.staging_addr, want.staging_addr);
        if (out_item_o.promote_addr !== want.promote_addr)
          report_mismatch("promote_addr", out_item_o.promote_addr, want.promote_addr);
        if (out_item_o.sector_count !== want.sector_count)
          report_mismatch("sector_count", 32'(out_item_o.sector_count), 32'(want.sector_count));
        if (out_item_o.byte_count !== want.byte_count)
          report_mismatch("byte_count", 32'(out_item_o.byte_count), 32'(want.byte_count));
        if (out_item_o.session_open !== want.session_open)
          report_mismatch("session_open", 32'(out_item_o.session_open),
                          32'(want.session_open));
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_commands();
    test_limit_extremes();
    test_zero_limits();
    test_random_limits();
    test_back_to_back_chunks();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS staged_image_update_sequencer");
    end else begin
      $display("FAIL staged_image_update_sequencer");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL staged_image_update_sequencer");
    $finish;
  end

endmodule
